// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/blpi_pkg.sv -----
// ----------------------------------------------------------------------------
// blpi_pkg
// shared types and codes for the bounded positional list
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blpi_pkg;

    localparam int FUNC_W = 4;
    localparam int ERR_W  = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd0;
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd3;
    localparam logic [FUNC_W-1:0] FN_INSERT     = 4'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE     = 4'd5;
    localparam logic [FUNC_W-1:0] FN_READ       = 4'd6;
    localparam logic [FUNC_W-1:0] FN_REVERSE    = 4'd7;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 4'd8;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_POS   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

    // broadcast shift command to every cell of the chain
    typedef struct packed {
        logic ins;   // open a slot at the split index, shifting toward the tail
        logic rem;   // close the slot at the split index, shifting toward the head
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/blpi_cell.sv -----
// ----------------------------------------------------------------------------
// blpi_cell
// one storage cell of the list chain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blpi_cell #(
    parameter int INDEX      = 0,
    parameter int CNT_W      = 6,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire blpi_pkg::cell_ctrl_t  ctrl,
    input  wire logic [CNT_W-1:0]      split,
    input  wire logic [CNT_W-1:0]      tail,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic [DATA_WIDTH-1:0] left,
    input  wire logic [DATA_WIDTH-1:0] right,
    output logic      [DATA_WIDTH-1:0] entry,
    output logic      [DATA_WIDTH-1:0] tap_split,
    output logic      [DATA_WIDTH-1:0] tap_tail
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  at_split;
    logic                  past_split;

    assign at_split   = (split == MY_IDX);
    assign past_split = (MY_IDX > split);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (at_split)
                entry_next = value;
            else if (past_split)
                entry_next = left;
        end
        else if (ctrl.rem && (at_split || past_split))
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry     = entry_reg;
    assign tap_split = at_split ? entry_reg : '0;
    assign tap_tail  = (tail == MY_IDX) ? entry_reg : '0;

endmodule

`default_nettype wire

// ----- rtl/blpi_chain.sv -----
// ----------------------------------------------------------------------------
// blpi_chain
// row of list cells with neighbor links and read-out buses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blpi_chain #(
    parameter int DEPTH      = 32,
    parameter int CNT_W      = 6,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  clk,
    input  wire blpi_pkg::cell_ctrl_t  ctrl,
    input  wire logic [CNT_W-1:0]      split,
    input  wire logic [CNT_W-1:0]      tail,
    input  wire logic [DATA_WIDTH-1:0] value,
    output logic      [DATA_WIDTH-1:0] head_word,
    output logic      [DATA_WIDTH-1:0] split_word,
    output logic      [DATA_WIDTH-1:0] tail_word
);

    logic [DATA_WIDTH-1:0] entries    [DEPTH];
    logic [DATA_WIDTH-1:0] taps_split [DEPTH];
    logic [DATA_WIDTH-1:0] taps_tail  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entries[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entries[i+1];
        end

        blpi_cell #(
            .INDEX      (i),
            .CNT_W      (CNT_W),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .split     (split),
            .tail      (tail),
            .value     (value),
            .left      (left_w),
            .right     (right_w),
            .entry     (entries[i]),
            .tap_split (taps_split[i]),
            .tap_tail  (taps_tail[i])
        );
    end

    // only one cell matches each index, so an or of the taps selects it
    always_comb
    begin
        split_word = '0;
        tail_word  = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            split_word = split_word | taps_split[i];
            tail_word  = tail_word | taps_tail[i];
        end
    end

    assign head_word = entries[0];

endmodule

`default_nettype wire

// ----- rtl/bounded_list_positional_insert_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_list_positional_insert_unit
// bounded ordered list with push, pop, positional insert, remove and read
// ----------------------------------------------------------------------------
// usage
//   a request word (func, value, position) is taken at a rising edge where
//   start is high and busy is low; busy stays low, so a request can be
//   issued every cycle
//   one result word follows per request, in the cycle after it is taken: done is high for
//   exactly that cycle and data, error, count, is_empty, first_value and
//   last_value are valid with it; the receiver cannot hold it off
//   the unit takes one request per cycle: the cell chain shifts its
//   entries at the same edge the request is taken
//   first and last values are read from the updated chain during the done
//   cycle, so the chain's tail read-out bus sets the output path
//   reversal only flips an order flag; the chain keeps physical order and
//   logical positions are mapped onto it
//   reset clears the count, the order flag and done; the entry cells are not
//   cleared and are never read beyond the count
//   a failing request returns its error code and leaves the list unchanged
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_list_positional_insert_unit #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [blpi_pkg::FUNC_W-1:0]       func,
    input  wire logic signed [DATA_WIDTH-1:0]      value,
    input  wire logic [$clog2(DEPTH+1)-1:0]        position,
    output logic                                   done,
    output logic signed [DATA_WIDTH-1:0]           data,
    output logic [blpi_pkg::ERR_W-1:0]             error,
    output logic [$clog2(DEPTH+1)-1:0]             count,
    output logic                                   is_empty,
    output logic signed [DATA_WIDTH-1:0]           first_value,
    output logic signed [DATA_WIDTH-1:0]           last_value
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // control state
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic                        rev_reg;
    logic                        rev_next;
    logic                        done_reg;

    // result word registers
    logic [DATA_WIDTH-1:0]       data_reg;
    logic [DATA_WIDTH-1:0]       data_next;
    logic [blpi_pkg::ERR_W-1:0]  err_reg;
    logic [blpi_pkg::ERR_W-1:0]  err_next;

    // request decode
    logic                        accept;
    logic                        full;
    logic                        empty;
    logic [CNT_W-1:0]            cnt_m1;
    logic [CNT_W-1:0]            split_idx;
    logic                        take_data;
    blpi_pkg::cell_ctrl_t        cell_ctrl;

    // chain read-out
    logic [DATA_WIDTH-1:0]       head_word;
    logic [DATA_WIDTH-1:0]       split_word;
    logic [DATA_WIDTH-1:0]       tail_word;
    logic [CNT_W-1:0]            tail_idx;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_FULL);
    assign empty  = (count_reg == '0);
    assign cnt_m1 = count_reg - CNT_ONE;

    // decode the request against the current count and order flag;
    // split_idx is the physical cell where the chain opens, closes or is read
    always_comb
    begin
        cell_ctrl  = '0;
        split_idx  = '0;
        take_data  = 1'b0;
        err_next   = blpi_pkg::ERR_OK;
        count_next = count_reg;
        rev_next   = rev_reg;
        case (func)
            blpi_pkg::FN_PUSH_FRONT:
            begin
                if (full)
                    err_next = blpi_pkg::ERR_FULL;
                else
                begin
                    cell_ctrl.ins = 1'b1;
                    split_idx     = rev_reg ? count_reg : '0;
                    count_next    = count_reg + CNT_ONE;
                end
            end
            blpi_pkg::FN_PUSH_BACK:
            begin
                if (full)
                    err_next = blpi_pkg::ERR_FULL;
                else
                begin
                    cell_ctrl.ins = 1'b1;
                    split_idx     = rev_reg ? '0 : count_reg;
                    count_next    = count_reg + CNT_ONE;
                end
            end
            blpi_pkg::FN_POP_FRONT:
            begin
                if (empty)
                    err_next = blpi_pkg::ERR_EMPTY;
                else
                begin
                    cell_ctrl.rem = 1'b1;
                    take_data     = 1'b1;
                    split_idx     = rev_reg ? cnt_m1 : '0;
                    count_next    = cnt_m1;
                end
            end
            blpi_pkg::FN_POP_BACK:
            begin
                if (empty)
                    err_next = blpi_pkg::ERR_EMPTY;
                else
                begin
                    cell_ctrl.rem = 1'b1;
                    take_data     = 1'b1;
                    split_idx     = rev_reg ? '0 : cnt_m1;
                    count_next    = cnt_m1;
                end
            end
            blpi_pkg::FN_INSERT:
            begin
                // position check comes before the full check
                if (position > count_reg)
                    err_next = blpi_pkg::ERR_POS;
                else if (full)
                    err_next = blpi_pkg::ERR_FULL;
                else
                begin
                    cell_ctrl.ins = 1'b1;
                    split_idx     = rev_reg ? (count_reg - position) : position;
                    count_next    = count_reg + CNT_ONE;
                end
            end
            blpi_pkg::FN_REMOVE:
            begin
                if (position >= count_reg)
                    err_next = blpi_pkg::ERR_POS;
                else
                begin
                    cell_ctrl.rem = 1'b1;
                    split_idx     = rev_reg ? (cnt_m1 - position) : position;
                    count_next    = cnt_m1;
                end
            end
            blpi_pkg::FN_READ:
            begin
                if (position >= count_reg)
                    err_next = blpi_pkg::ERR_POS;
                else
                begin
                    take_data = 1'b1;
                    split_idx = rev_reg ? (cnt_m1 - position) : position;
                end
            end
            blpi_pkg::FN_REVERSE:
            begin
                if (!empty)
                    rev_next = !rev_reg;
            end
            blpi_pkg::FN_CLEAR:
            begin
                count_next = '0;
                rev_next   = 1'b0;
            end
            default:
            begin
                // unused codes leave everything as is
            end
        endcase

        // nothing moves unless the request is taken
        if (!accept)
        begin
            cell_ctrl  = '0;
            count_next = count_reg;
            rev_next   = rev_reg;
        end
    end

    // popped or read word comes from the chain before it shifts
    assign data_next = take_data ? split_word : '0;

    // tail index follows the registered count, so during the done cycle it
    // points at the last cell of the updated list
    assign tail_idx = cnt_m1;

    blpi_chain #(
        .DEPTH      (DEPTH),
        .CNT_W      (CNT_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_chain (
        .clk        (clk),
        .ctrl       (cell_ctrl),
        .split      (split_idx),
        .tail       (tail_idx),
        .value      (value),
        .head_word  (head_word),
        .split_word (split_word),
        .tail_word  (tail_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rev_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rev_reg   <= rev_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_next;
            err_reg  <= err_next;
        end
    end

    // result word
    assign done        = done_reg;
    assign data        = data_reg;
    assign error       = err_reg;
    assign count       = count_reg;
    assign is_empty    = empty;
    // physical cell 0 is the logical front unless the order is flipped
    assign first_value = empty ? '0 : (rev_reg ? tail_word : head_word);
    assign last_value  = empty ? '0 : (rev_reg ? head_word : tail_word);

endmodule

`default_nettype wire

// ----- rtl/blpi_checker.sv -----
// ----------------------------------------------------------------------------
// blpi_checker
// port-level checks for the bounded positional list
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module blpi_checker #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [blpi_pkg::ERR_W-1:0]    error,
    input wire logic [$clog2(DEPTH+1)-1:0]    count,
    input wire logic                          is_empty,
    input wire logic signed [DATA_WIDTH-1:0]  first_value,
    input wire logic signed [DATA_WIDTH-1:0]  last_value
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    // one result word per taken request, in the cycle after it
    `ASSERT_NEXT(a_word_follows, clk, rst_n, start && !busy, done)
    `ASSERT_NEXT(a_no_spurious_word, clk, rst_n, !(start && !busy), !done)

    `ASSERT_IMPL(a_empty_flag, clk, rst_n, done, is_empty == (count == '0))
    `ASSERT_IMPL(a_empty_ends_zero, clk, rst_n, done && is_empty,
        first_value == '0 && last_value == '0)
    `ASSERT_IMPL(a_count_bound, clk, rst_n, done,
        count <= CNT_FULL && (error != blpi_pkg::ERR_FULL || count == CNT_FULL))

endmodule

bind bounded_list_positional_insert_unit blpi_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_blpi_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .error       (error),
    .count       (count),
    .is_empty    (is_empty),
    .first_value (first_value),
    .last_value  (last_value)
);

`default_nettype wire
